// ===== hdl/lcde_pkg.sv =====
`default_nettype none
package lcde_pkg;
   localparam int CordicSteps = 24;
   localparam int RegIdxWidth = 3;
   localparam logic [RegIdxWidth-1:0] RegEnabledPhases   = 3'd0;
   localparam logic [RegIdxWidth-1:0] RegMinTerminal     = 3'd1;
   localparam logic [RegIdxWidth-1:0] RegMinRestraint    = 3'd2;
   localparam logic [RegIdxWidth-1:0] RegBiasSlope       = 3'd3;
   localparam logic [RegIdxWidth-1:0] RegPickup          = 3'd4;
   localparam logic [RegIdxWidth-1:0] RegAngleTolerance  = 3'd5;
   localparam logic [RegIdxWidth-1:0] RegOperateDelay    = 3'd6;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_SQ    = 10'b0000000010,
      ST_SQRT  = 10'b0000000100,
      ST_MIN   = 10'b0000001000,
      ST_CORD  = 10'b0000010000,
      ST_ANG   = 10'b0000100000,
      ST_BIAS  = 10'b0001000000,
      ST_CMP   = 10'b0010000000,
      ST_TIMER = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
         5'd20: v = 32'd652;       5'd21: v = 32'd326;
         5'd22: v = 32'd163;       5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/line_current_differential_element_unit.sv =====
// Line current differential element (87L), one phase per transfer.
// Request channel (req_*): one phase's local and remote phasors plus the
// microseconds since that phase was last evaluated. A transfer happens when
// req_valid is high and req_stall low. req_stall is held high from the
// transfer until the result has been taken.
// Response channel (rsp_*): one result per request: echoed phase, started,
// tripped. rsp_valid holds with stable payload while rsp_stall is high.
// Steps: three magnitudes, each a squaring pass of two multiplies then a root
// of one bit per cycle, then with the angle check on (angle_tolerance nonzero)
// two CORDIC runs of one load and 24 iterations on one shift-add unit, then
// the bias multiply and the timer update. With the angle check off there are
// no CORDIC runs. Both terminals below the minimum give the result after the
// remote magnitude, with no operate magnitude; a disabled phase gives it
// straight from idle. The next request can transfer on the edge after the
// result transfer. One request is in flight at a time.
// CSR channel (csr_*): register writes, always ready; write only when idle.
// Reset (synchronous, active high) restores register defaults, clears all
// phase timers and empties the pipeline.
`default_nettype none
module line_current_differential_element_unit #(
   parameter int NUM_PHASES    = 3,
   parameter int CURRENT_WIDTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [1:0]                      req_phase,
   input  wire logic signed [CURRENT_WIDTH-1:0] req_local_real,
   input  wire logic signed [CURRENT_WIDTH-1:0] req_local_imag,
   input  wire logic signed [CURRENT_WIDTH-1:0] req_remote_real,
   input  wire logic signed [CURRENT_WIDTH-1:0] req_remote_imag,
   input  wire logic [15:0]                     req_elapsed_us,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [1:0]                           rsp_result_phase,
   output logic                                 rsp_started,
   output logic                                 rsp_tripped,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lcde_pkg::RegIdxWidth-1:0] csr_index,
   input  wire logic [31:0]                     csr_data
);
   import lcde_pkg::*;

   localparam int CW  = CURRENT_WIDTH;
   localparam int DW  = CW + 1;          // difference width
   localparam int SQW = 2 * DW + 2;      // sum of squares, even for root pairs
   localparam int MW  = DW + 1;          // magnitude width
   localparam int RW  = MW + 1;          // r2 width
   localparam int CXW = CW + 16 + 8;     // cordic datapath
   localparam int PW  = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
   localparam int SQCW = $clog2(MW + 1);

   state_type state_ff, state_in;

   logic [2:0]  en_ff;
   logic [15:0] min_term_ff, min_rest_ff, slope_ff, ang_tol_ff;
   logic [16:0] pickup_ff;
   logic [31:0] delay_ff;
   logic [31:0] timer_ff [NUM_PHASES];

   logic [1:0] phase_ff;
   logic signed [DW-1:0] lr_ff, li_ff, rr_ff, ri_ff;
   logic [15:0] elapsed_ff;
   logic [1:0]  pass_ff;            // 0 local, 1 remote, 2 operate
   logic        mul_sel_ff;
   logic signed [DW-1:0] mul_a;
   logic [2*DW-1:0] prod;
   logic [SQW-1:0] rad_ff;
   logic [MW-1:0]  root_ff;
   logic [SQW+1:0] rem_ff;
   logic [SQCW-1:0] sq_cnt_ff;
   logic [MW-1:0] mag_l_ff, mag_r_ff, op_ff;
   logic cpass_ff, cload_ff;
   logic signed [CXW-1:0] cx_ff, cy_ff;
   logic [31:0] cz_ff, ang_l_ff;
   logic [4:0]  ccnt_ff;
   logic [RW+15:0] bias_ff;
   logic started_ff, tripped_ff, kill_ff;
   logic rsp_valid_ff;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_phase = phase_ff;
   assign rsp_started = started_ff;
   assign rsp_tripped = tripped_ff;

   // shared squarer
   always_comb begin
      case (pass_ff)
         2'd0: mul_a = mul_sel_ff ? li_ff : lr_ff;
         2'd1: mul_a = mul_sel_ff ? ri_ff : rr_ff;
         default: mul_a = mul_sel_ff ? (li_ff - ri_ff) : (lr_ff - rr_ff);
      endcase
   end
   logic [DW-1:0] mul_abs;
   assign mul_abs = mul_a[DW-1] ? DW'(-mul_a) : DW'(mul_a);
   assign prod = mul_abs * mul_abs;

   // root trial
   logic [SQW+1:0] trial;
   logic [SQW+1:0] rem_sh;
   assign rem_sh = {rem_ff[SQW-1:0], rad_ff[SQW-1 -: 2]};
   assign trial  = {{(SQW+2-MW-2){1'b0}}, root_ff, 2'b01};

   // cordic source
   logic signed [DW-1:0] cxs, cys;
   assign cxs = cpass_ff ? rr_ff : lr_ff;
   assign cys = cpass_ff ? ri_ff : li_ff;
   logic signed [CXW-1:0] xsh, ysh;
   assign xsh = cx_ff >>> ccnt_ff;
   assign ysh = cy_ff >>> ccnt_ff;
   logic [31:0] cz_nx;
   assign cz_nx = (cy_ff >= 0) ? cz_ff + atan_entry(ccnt_ff) : cz_ff - atan_entry(ccnt_ff);
   logic czero;
   assign czero = (cxs == 0) && (cys == 0);

   logic [15:0] ang_d, ang_abs;
   logic [31:0] cz_r;
   assign cz_r = cz_ff + 32'h8000;
   assign ang_d = 16'((ang_l_ff + 32'h8000) >> 16) - cz_r[31:16];
   assign ang_abs = ang_d[15] ? 16'(17'h10000 - {1'b0, ang_d}) : ang_d;

   logic term_small;
   assign term_small = (mag_l_ff < MW'(min_term_ff)) && (mag_r_ff < MW'(min_term_ff));

   logic [RW-1:0] r2;
   assign r2 = RW'(mag_l_ff) + RW'(mag_r_ff);
   logic [RW+16:0] lhs, rhs;
   assign lhs = (RW+17)'(op_ff) << 15;
   assign rhs = ((RW+17)'(pickup_ff) << 15) + (RW+17)'(bias_ff);
   logic [32:0] tsum;
   logic [PW-1:0] pidx;
   assign pidx = phase_ff[PW-1:0];
   assign tsum = {1'b0, timer_ff[pidx]} + 33'(elapsed_ff);

   logic p_ok;
   assign p_ok = (32'(req_phase) < NUM_PHASES) && en_ff[req_phase];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = p_ok ? ST_SQ : ST_OUT;
         ST_SQ:   if (mul_sel_ff) state_in = ST_SQRT;
         ST_SQRT: if (32'(sq_cnt_ff) == MW - 1)
                     state_in = (pass_ff == 2'd1) ? ST_MIN
                              : (pass_ff == 2'd2) ? ST_CORD : ST_SQ;
         ST_MIN:  state_in = term_small ? ST_OUT : ST_SQ;
         ST_CORD: if (ang_tol_ff == 16'd0) state_in = ST_BIAS;
                  else if (ccnt_ff == 5'(CordicSteps - 1) && cpass_ff) state_in = ST_ANG;
         ST_ANG:  state_in = ST_BIAS;
         ST_BIAS: state_in = ST_CMP;
         ST_CMP:  state_in = ST_TIMER;
         ST_TIMER: state_in = ST_OUT;
         ST_OUT:  if (!rsp_stall && rsp_valid_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         en_ff <= 3'd7; min_term_ff <= '0; min_rest_ff <= '0; slope_ff <= '0;
         pickup_ff <= '0; ang_tol_ff <= '0; delay_ff <= '0;
         for (int p = 0; p < NUM_PHASES; p++) timer_ff[p] <= '0;
         rsp_valid_ff <= 1'b0;
         kill_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               RegEnabledPhases:  en_ff <= csr_data[2:0];
               RegMinTerminal:    min_term_ff <= csr_data[15:0];
               RegMinRestraint:   min_rest_ff <= csr_data[15:0];
               RegBiasSlope:      slope_ff <= csr_data[15:0];
               RegPickup:         pickup_ff <= csr_data[16:0];
               RegAngleTolerance: ang_tol_ff <= csr_data[15:0];
               RegOperateDelay:   delay_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= req_valid && !p_ok;
               kill_ff <= 1'b0;
               if (req_valid) begin
                  phase_ff <= req_phase;
                  lr_ff <= DW'(req_local_real);  li_ff <= DW'(req_local_imag);
                  rr_ff <= DW'(req_remote_real); ri_ff <= DW'(req_remote_imag);
                  elapsed_ff <= req_elapsed_us;
                  pass_ff <= 2'd0; mul_sel_ff <= 1'b0;
                  started_ff <= 1'b0; tripped_ff <= 1'b0;
               end
            end
            ST_SQ: begin
               mul_sel_ff <= ~mul_sel_ff;
               if (!mul_sel_ff) rad_ff <= SQW'(prod);
               else rad_ff <= rad_ff + SQW'(prod);
               root_ff <= '0; rem_ff <= '0; sq_cnt_ff <= '0;
            end
            ST_SQRT: begin
               sq_cnt_ff <= sq_cnt_ff + 1'b1;
               rad_ff <= rad_ff << 2;
               if (rem_sh >= trial) begin
                  rem_ff <= rem_sh - trial;
                  root_ff <= {root_ff[MW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  root_ff <= {root_ff[MW-2:0], 1'b0};
               end
               if (32'(sq_cnt_ff) == MW - 1) begin
                  pass_ff <= pass_ff + 2'd1;
                  cpass_ff <= 1'b0; ccnt_ff <= '0; cload_ff <= 1'b0;
                  case (pass_ff)
                     2'd0: mag_l_ff <= (rem_sh >= trial) ? {root_ff[MW-2:0], 1'b1}
                                                         : {root_ff[MW-2:0], 1'b0};
                     2'd1: mag_r_ff <= (rem_sh >= trial) ? {root_ff[MW-2:0], 1'b1}
                                                         : {root_ff[MW-2:0], 1'b0};
                     default: op_ff <= (rem_sh >= trial) ? {root_ff[MW-2:0], 1'b1}
                                                         : {root_ff[MW-2:0], 1'b0};
                  endcase
               end
            end
            ST_MIN: begin
               if (term_small) begin
                  timer_ff[pidx] <= '0;
                  rsp_valid_ff <= 1'b1;
               end
               ccnt_ff <= '0; cpass_ff <= 1'b0;
            end
            ST_CORD: begin
               if (ccnt_ff == 5'd0 && !cload_ff) begin
                  // initial rotation loaded in first cycle of each pass
                  cload_ff <= 1'b1;
                  if (cxs < 0) begin
                     cx_ff <= CXW'(-cxs) <<< 16; cy_ff <= CXW'(-cys) <<< 16;
                     cz_ff <= 32'h80000000;
                  end else begin
                     cx_ff <= CXW'(cxs) <<< 16; cy_ff <= CXW'(cys) <<< 16;
                     cz_ff <= 32'h0;
                  end
               end else begin
                  if (cy_ff >= 0) begin
                     cx_ff <= cx_ff + ysh; cy_ff <= cy_ff - xsh;
                  end else begin
                     cx_ff <= cx_ff - ysh; cy_ff <= cy_ff + xsh;
                  end
                  if (ccnt_ff == 5'(CordicSteps - 1)) begin
                     ccnt_ff <= '0; cload_ff <= 1'b0;
                     cpass_ff <= 1'b1;
                     if (!cpass_ff) ang_l_ff <= czero ? 32'h0 : cz_nx;
                     cz_ff <= (cpass_ff && czero) ? 32'h0 : cz_nx;
                  end else begin
                     ccnt_ff <= ccnt_ff + 1'b1;
                     cz_ff <= cz_nx;
                  end
               end
            end
            ST_ANG: begin
               if (ang_abs > ang_tol_ff) begin
                  timer_ff[pidx] <= '0;
                  kill_ff <= 1'b1;
               end
            end
            ST_BIAS: begin
               bias_ff <= (r2 >= RW'({min_rest_ff, 1'b0})) ? (RW+16)'(slope_ff * r2) : '0;
            end
            ST_CMP: begin
               if (!kill_ff && lhs < rhs) begin
                  timer_ff[pidx] <= '0;
                  kill_ff <= 1'b1;
               end
            end
            ST_TIMER: begin
               rsp_valid_ff <= 1'b1;
               if (!kill_ff) begin
                  started_ff <= 1'b1;
                  if (delay_ff != 32'd0) begin
                     timer_ff[pidx] <= tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
                     tripped_ff <= (tsum[32] ? 32'hFFFFFFFF : tsum[31:0]) >= delay_ff;
                  end else begin
                     tripped_ff <= 1'b1;
                  end
               end
            end
            ST_OUT: begin
               if (!rsp_stall && rsp_valid_ff) rsp_valid_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== bench/line_current_differential_element_unit_tb.sv =====
`timescale 1ns / 100ps
module line_current_differential_element_unit_tb;
   import lcde_pkg::*;

   localparam logic [RegIdxWidth-1:0] RegUnused = 3'd7;

   typedef struct {
      bit                 is_reg;
      logic [2:0]         idx;
      logic [31:0]        val;
      logic [1:0]         ph;
      logic signed [15:0] lr, li, rr, ri;
      logic [15:0]        el;
      bit                 typed;
      bit                 s, t;
   } row_type;

   typedef struct {
      logic [1:0] ph;
      bit         s, t;
   } verdict_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_phase = 0;
   logic signed [15:0] req_local_real = 0, req_local_imag = 0;
   logic signed [15:0] req_remote_real = 0, req_remote_imag = 0;
   logic [15:0] req_elapsed_us = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_result_phase;
   logic rsp_started, rsp_tripped;
   logic csr_valid = 0;
   logic csr_ready;
   logic [RegIdxWidth-1:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   line_current_differential_element_unit DUT (.*);

   always #2 clock = ~clock;

   // predictor state
   logic [2:0]  en_phases;
   logic [15:0] min_term, min_restr, slope, ang_tol;
   logic [16:0] pickup;
   logic [31:0] op_delay;
   logic [31:0] op_timer [3];
   const logic [31:0] arctan [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   verdict_type verdicts[$];
   int send_idle, stall_idle;
   int n_err = 0, n_items = 0, n_results = 0, n_trips = 0, n_starts = 0;

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned mag(longint re, longint im);
      return root_floor(longint'(re * re) + longint'(im * im));
   endfunction

   function automatic logic [15:0] phasor_angle(longint x, longint y);
      logic [31:0] z = 0;
      longint nx;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      x *= 65536;
      y *= 65536;
      for (int i = 0; i < 24; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += arctan[i];
         end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= arctan[i];
         end
         x = nx;
      end
      return 16'((z + 32'h8000) >> 16);
   endfunction

   function automatic verdict_type judge_phase(logic [1:0] ph, longint lr, longint li,
                                               longint rr, longint ri, logic [15:0] el);
      verdict_type v;
      longint unsigned ml, mr, op, r2, lhs, rhs, tsum;
      logic [15:0] d, ad;
      v.ph = ph;
      v.s = 0;
      v.t = 0;
      if (ph > 2 || !en_phases[ph]) return v;
      ml = mag(lr, li);
      mr = mag(rr, ri);
      if (ml < min_term && mr < min_term) begin
         op_timer[ph] = 0;
         return v;
      end
      op = mag(lr - rr, li - ri);
      r2 = ml + mr;
      if (ang_tol > 0) begin
         d = phasor_angle(lr, li) - phasor_angle(rr, ri);
         ad = d >= 16'd32768 ? 16'(17'h10000 - d) : d;
         if (ad > ang_tol) begin
            op_timer[ph] = 0;
            return v;
         end
      end
      lhs = op << 15;
      rhs = longint'(pickup) << 15;
      if (r2 >= 2 * longint'(min_restr)) rhs += longint'(slope) * r2;
      if (lhs < rhs) begin
         op_timer[ph] = 0;
         return v;
      end
      v.s = 1;
      if (op_delay > 0) begin
         tsum = longint'(op_timer[ph]) + el;
         op_timer[ph] = tsum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : tsum[31:0];
         v.t = op_timer[ph] >= op_delay;
      end else begin
         v.t = 1;
      end
      return v;
   endfunction

   task automatic reg_write(logic [2:0] idx, logic [31:0] val);
      req_valid <= 0;
      while (verdicts.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         RegEnabledPhases:  en_phases = val[2:0];
         RegMinTerminal:    min_term = val[15:0];
         RegMinRestraint:   min_restr = val[15:0];
         RegBiasSlope:      slope = val[15:0];
         RegPickup:         pickup = val[16:0];
         RegAngleTolerance: ang_tol = val[15:0];
         RegOperateDelay:   op_delay = val;
         default: ;
      endcase
   endtask

   task automatic send_phase(row_type r);
      verdict_type v;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_phase <= r.ph;
      req_local_real <= r.lr;
      req_local_imag <= r.li;
      req_remote_real <= r.rr;
      req_remote_imag <= r.ri;
      req_elapsed_us <= r.el;
      do @(posedge clock); while (req_stall);
      v = judge_phase(r.ph, r.lr, r.li, r.rr, r.ri, r.el);
      if (r.typed) begin
         v.s = r.s;
         v.t = r.t;
      end
      verdicts.push_back(v);
      n_items++;
   endtask

   always @(posedge clock) begin
      verdict_type e;
      rsp_stall <= !reset && $urandom_range(99) < stall_idle;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         n_starts += rsp_started;
         n_trips += rsp_tripped;
         if (verdicts.size() == 0) begin
            $error("unexpected result transfer, phase %0d", rsp_result_phase);
            n_err++;
         end else begin
            e = verdicts.pop_front();
            if (rsp_result_phase !== e.ph) begin
               $error("result_phase expected %0d got %0d", e.ph, rsp_result_phase);
               n_err++;
            end
            if (rsp_started !== e.s) begin
               $error("started expected %0d got %0d", e.s, rsp_started);
               n_err++;
            end
            if (rsp_tripped !== e.t) begin
               $error("tripped expected %0d got %0d", e.t, rsp_tripped);
               n_err++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("timeout, %0d results outstanding", verdicts.size());
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      row_type dir[26];
      row_type r;
      longint base_r, base_i;
      en_phases = 3'b111;
      min_term = 0;
      min_restr = 0;
      slope = 0;
      ang_tol = 0;
      pickup = 0;
      op_delay = 0;
      foreach (op_timer[i]) op_timer[i] = 0;
      send_idle = 34;
      stall_idle = 61;
      // is_reg idx val ph lr li rr ri el typed s t
      dir[0]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1};
      dir[1]  = '{0, 0, 0, 1, 32767, 32767, 32767, 32767, 65535, 1, 1, 1};
      dir[2]  = '{0, 0, 0, 2, -32768, -32768, -32768, -32768, 0, 1, 1, 1};
      dir[3]  = '{0, 0, 0, 3, 1234, -5, 77, 32767, 5, 1, 0, 0};
      dir[4]  = '{0, 0, 0, 0, -32768, 32767, 32767, -32768, 1, 1, 1, 1};
      dir[5]  = '{1, RegEnabledPhases, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      dir[6]  = '{0, 0, 0, 1, 30000, 0, -30000, 0, 9, 1, 0, 0};
      dir[7]  = '{1, RegEnabledPhases, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      dir[8]  = '{1, RegMinTerminal, 1000, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      dir[9]  = '{0, 0, 0, 0, 10, 10, 20, -20, 3, 1, 0, 0};
      dir[10] = '{1, RegMinTerminal, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      dir[11] = '{1, RegPickup, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      dir[12] = '{0, 0, 0, 0, 1000, 0, 1000, 0, 3, 1, 0, 0};
      dir[13] = '{0, 0, 0, 0, 1000, 0, -1000, 0, 3, 1, 1, 1};
      dir[14] = '{1, RegBiasSlope, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      dir[15] = '{1, RegAngleTolerance, 1000, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      dir[16] = '{0, 0, 0, 2, 1000, 0, -1000, 0, 3, 1, 0, 0};
      dir[17] = '{0, 0, 0, 2, 1000, 0, 0, 1000, 3, 1, 0, 0};
      dir[18] = '{1, RegAngleTolerance, 40000, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      dir[19] = '{0, 0, 0, 2, 1000, 0, -1000, 0, 3, 0, 0, 0};
      dir[20] = '{1, RegMinRestraint, 65535, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      dir[21] = '{1, RegOperateDelay, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      dir[22] = '{0, 0, 0, 1, 30000, -3, -30000, 4, 60, 0, 0, 0};
      dir[23] = '{0, 0, 0, 1, 30000, -3, -30000, 4, 60, 0, 0, 0};
      dir[24] = '{1, RegOperateDelay, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      dir[25] = '{0, 0, 0, 1, -32768, 0, 32767, 0, 65535, 0, 0, 0};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (dir[i]) begin
         if (dir[i].is_reg) reg_write(dir[i].idx, dir[i].val);
         else send_phase(dir[i]);
      end
      reg_write(RegPickup, 131071);
      reg_write(RegBiasSlope, 65535);
      send_phase('{0, 0, 0, 0, -32768, -32768, 32767, 32767, 1, 0, 0, 0});
      reg_write(RegUnused, 0);
      for (int mode = 0; mode < 3; mode++) begin
         send_idle = mode == 0 ? 34 : mode == 1 ? 61 : 0;
         stall_idle = mode == 0 ? 61 : mode == 1 ? 34 : 0;
         for (int blk = 0; blk < 9; blk++) begin
            reg_write(RegEnabledPhases, $urandom_range(3) == 0 ? $urandom_range(7) : 7);
            reg_write(RegMinTerminal, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000));
            reg_write(RegMinRestraint, $urandom_range(2) == 0 ? $urandom : $urandom_range(3000));
            reg_write(RegBiasSlope, $urandom_range(2) == 0 ? $urandom : $urandom_range(20000));
            reg_write(RegPickup, $urandom_range(3) == 0 ? $urandom : $urandom_range(4000));
            case ($urandom_range(3))
               0: reg_write(RegAngleTolerance, 0);
               1: reg_write(RegAngleTolerance, $urandom_range(65535));
               default: reg_write(RegAngleTolerance, $urandom_range(12000));
            endcase
            case ($urandom_range(3))
               0: reg_write(RegOperateDelay, 0);
               1: reg_write(RegOperateDelay, $urandom);
               default: reg_write(RegOperateDelay, $urandom_range(200000));
            endcase
            for (int k = 0; k < 24; k++) begin
               r = '{default: 0};
               r.ph = $urandom_range(3) == 0 ? 2'($urandom) : 2'($urandom_range(2));
               r.el = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(20000));
               base_r = $signed(16'($urandom));
               base_i = $signed(16'($urandom));
               if ($urandom_range(3) == 0) base_r = base_r >>> $urandom_range(15);
               if ($urandom_range(3) == 0) base_i = base_i >>> $urandom_range(15);
               r.lr = 16'(base_r);
               r.li = 16'(base_i);
               case ($urandom_range(4))
                  0: begin
                     r.rr = 16'(-base_r + $signed($urandom_range(400)) - 200);
                     r.ri = 16'(-base_i + $signed($urandom_range(400)) - 200);
                  end
                  1: begin
                     r.rr = 16'(base_r >>> $urandom_range(3));
                     r.ri = 16'(base_i >>> $urandom_range(3));
                  end
                  2: begin
                     r.rr = 16'(-(base_r >>> 1));
                     r.ri = 16'(-(base_i >>> 1));
                  end
                  default: begin
                     r.rr = 16'($urandom);
                     r.ri = 16'($urandom);
                  end
               endcase
               send_phase(r);
            end
         end
      end
      req_valid <= 0;
      while (verdicts.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("%0d requests, %0d results (%0d started, %0d tripped), %0d mismatches",
               n_items, n_results, n_starts, n_trips, n_err);
      $display("register sweeps under three idle/stall mixes, extremes and directed cases");
      if (n_err == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
